>>> hdl/i64da_pkg.sv
// Package for the 64-bit integer to decimal text unit.
// Holds the widths, character codes and the BCD word type.
// No dependencies.
package i64da_pkg;

  // Input number and output character widths
  localparam int NUM_W  = 64;
  localparam int CHAR_W = 7;

  // BCD accumulator: room for the longest magnitude
  localparam int NUM_DIGITS = 20;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int CNT_W      = $clog2(NUM_DIGITS + 1);

  // Binary bits folded into the BCD word per conversion cycle
  localparam int BITS_PER_STEP = 4;
  localparam int NUM_STEPS     = NUM_W / BITS_PER_STEP;
  localparam int STEP_CNT_W    = $clog2(NUM_STEPS);

  // Character codes
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

  typedef logic [BCD_W-1:0] bcd_t;

endpackage

>>> hdl/i64da_num_if.sv
// Channel that carries the signed numbers into the unit.
// Depends on i64da_pkg for the number width.
interface i64da_num_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [i64da_pkg::NUM_W-1:0]   number_in;

  modport source (output valid, output number_in, input ready);
  modport sink   (input valid, input number_in, output ready);
endinterface

>>> hdl/i64da_char_if.sv
// Channel that carries the decimal text out, one character per item.
// Depends on i64da_pkg for the character width.
interface i64da_char_if;
  logic                               valid;
  logic                               ready;
  logic [i64da_pkg::CHAR_W-1:0]       char_code;
  logic                               last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

>>> hdl/i64da_dabble_step.sv
// Shared shift-and-add-3 unit: folds BITS_PER_STEP binary bits into a BCD word.
// Depends on i64da_pkg.
module i64da_dabble_step (
  input  i64da_pkg::bcd_t                          bcd_in,
  input  logic [i64da_pkg::BITS_PER_STEP-1:0]      bits_in,
  output i64da_pkg::bcd_t                          bcd_out
);
  import i64da_pkg::*;

  localparam logic [DIGIT_W-1:0] ADJ_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] ADJ_ADD   = 4'd3;

  // Per bit: correct every digit of five or more, then shift the bit in
  always_comb begin
    bcd_t acc;
    acc = bcd_in;
    for (int b = BITS_PER_STEP - 1; b >= 0; b--) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (acc[d*DIGIT_W +: DIGIT_W] >= ADJ_LIMIT) begin
          acc[d*DIGIT_W +: DIGIT_W] = acc[d*DIGIT_W +: DIGIT_W] + ADJ_ADD;
        end
      end
      acc = {acc[BCD_W-2:0], bits_in[b]};
    end
    bcd_out = acc;
  end

endmodule

>>> hdl/int64_to_decimal_ascii_unit.sv
// Signed 64-bit integer to decimal ASCII text, one character per output item,
// most significant first, with a leading '-' for negative numbers and no
// leading zeros. After a number is accepted the unit folds the magnitude,
// four bits a cycle, through the shared shift-and-add-3 unit into a 20-digit
// BCD word, then shifts out the leading zeros (keeping at least one digit),
// emits the sign if negative, and then hands out one digit per free output
// slot. The suppressed zeros and the digits together always make 20. The unit
// takes a new number only once the last character of the previous one sits in
// the output register.
// Depends on i64da_pkg, i64da_num_if, i64da_char_if and i64da_dabble_step.
module int64_to_decimal_ascii_unit (
  input logic          clk,
  input logic          rst,
  i64da_num_if.sink    number,
  i64da_char_if.source text
);
  import i64da_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CONV, S_SKIP, S_SIGN, S_EMIT} state_t;

  state_t                  state;
  logic [NUM_W-1:0]        raw;
  logic [NUM_W-1:0]        bin;
  bcd_t                    bcd;
  bcd_t                    bcd_next;
  logic [STEP_CNT_W-1:0]   step_cnt;
  logic [CNT_W-1:0]        dig_left;
  logic                    neg;
  logic                    out_valid;
  logic [CHAR_W-1:0]       out_char;
  logic                    out_last;
  logic                    out_free;
  logic                    out_load;
  logic [DIGIT_W-1:0]      top_digit;

  i64da_dabble_step u_step (
    .bcd_in  (bcd),
    .bits_in (bin[NUM_W-1 -: BITS_PER_STEP]),
    .bcd_out (bcd_next)
  );

  assign raw       = number.number_in;
  assign top_digit = bcd[BCD_W-1 -: DIGIT_W];
  assign out_free  = !out_valid || text.ready;
  assign out_load  = out_free && (state == S_SIGN || state == S_EMIT);

  assign number.ready   = (state == S_IDLE);
  assign text.valid     = out_valid;
  assign text.char_code = out_char;
  assign text.last_char = out_last;

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Drop the held item once taken, unless a new one loads below
      if (text.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (number.valid) begin
            neg      <= raw[NUM_W-1];
            bin      <= raw[NUM_W-1] ? (~raw + NUM_W'(1)) : raw;
            bcd      <= '0;
            step_cnt <= '0;
            state    <= S_CONV;
          end
        end
        S_CONV: begin
          // Fold the next bits of the magnitude into the BCD word
          bcd      <= bcd_next;
          bin      <= bin << BITS_PER_STEP;
          step_cnt <= step_cnt + STEP_CNT_W'(1);
          if (step_cnt == STEP_CNT_W'(NUM_STEPS - 1)) begin
            dig_left <= CNT_W'(NUM_DIGITS);
            state    <= S_SKIP;
          end
        end
        S_SKIP: begin
          // Shift out leading zeros, keeping at least one digit
          if (top_digit == '0 && dig_left != CNT_W'(1)) begin
            bcd      <= bcd << DIGIT_W;
            dig_left <= dig_left - CNT_W'(1);
          end else begin
            state <= neg ? S_SIGN : S_EMIT;
          end
        end
        S_SIGN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_char  <= ASCII_MINUS;
            out_last  <= 1'b0;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Hand out one digit per free output slot
          if (out_free) begin
            out_valid <= 1'b1;
            out_char  <= ASCII_ZERO + CHAR_W'(top_digit);
            out_last  <= (dig_left == CNT_W'(1));
            bcd       <= bcd << DIGIT_W;
            dig_left  <= dig_left - CNT_W'(1);
            if (dig_left == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    number.valid && number.ready |=> state == S_CONV)
    else $error("accepted number did not start conversion");

  a_bin_drained: assert property (@(posedge clk) disable iff (rst)
    state == S_SKIP && $past(state) == S_CONV |-> bin == '0)
    else $error("magnitude not fully folded into BCD");

  a_bcd_digit: assert property (@(posedge clk) disable iff (rst)
    state == S_SKIP |-> top_digit <= DIGIT_W'(9))
    else $error("BCD digit out of range");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> dig_left != '0)
    else $error("emitting with no digits left");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && out_free && dig_left == CNT_W'(1)
    |=> out_valid && out_last && state == S_IDLE)
    else $error("final digit not flagged or sequencer not back to idle");
`endif

endmodule
